// File: hw/rtl/mfb_pkg.sv
// mfb_pkg: shared constants and a helper function of the max-flow block
// no dependencies
package mfb_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 64;
  localparam int unsigned VERTEX_W = 7;
  localparam int unsigned CAP_W = 16;
  localparam int unsigned FLOW_W = 32;
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [APB_AW-1:0] REG_VERTEX_COUNT = 3'd0;
  localparam logic [VERTEX_W-1:0] VERTEX_COUNT_RST = 7'd2;

  function automatic logic [FLOW_W-1:0] sat_add(input logic [FLOW_W-1:0] a,
                                                 input logic [FLOW_W-1:0] b);
    logic [FLOW_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[FLOW_W] ? '1 : s[FLOW_W-1:0];
  endfunction

endpackage

// File: hw/rtl/mfb_edge_if.sv
// mfb_edge_if: valid/ready channel that carries one directed edge
// depends on mfb_pkg
interface mfb_edge_if;
  import mfb_pkg::*;

  logic                valid;
  logic                ready;
  logic [VERTEX_W-1:0] from_vertex;
  logic [VERTEX_W-1:0] to_vertex;
  logic [CAP_W-1:0]    edge_capacity;
  logic                last_edge;

  modport source (output valid, from_vertex, to_vertex, edge_capacity, last_edge,
                  input ready);
  modport sink (input valid, from_vertex, to_vertex, edge_capacity, last_edge,
                output ready);
endinterface

// File: hw/rtl/mfb_flow_if.sv
// mfb_flow_if: valid/ready channel that carries one max-flow result
// depends on mfb_pkg
interface mfb_flow_if;
  import mfb_pkg::*;

  logic              valid;
  logic              ready;
  logic [FLOW_W-1:0] flow_value;

  modport source (output valid, flow_value, input ready);
  modport sink (input valid, flow_value, output ready);
endinterface

// File: hw/rtl/max_flow_bfs_augment_top.sv
// max_flow_bfs_augment_top: edmonds-karp max flow over a residual matrix memory
// depends on mfb_pkg, mfb_edge_if, mfb_flow_if
//
// usage: edges come in on edge_i, one item per edge; each is added to the
// residual matrix memory by a read-modify-write while edge_i is not ready.
// the item with last_edge set starts the flow computation. each search first
// clears all n seen marks, then pops each reached vertex and reads and checks
// the n matrix cells in its row. for each path found, a walk along the parents
// finds the bottleneck and a second updates the forward and reverse residuals.
// all of it is bound by the one read and one write port of the matrix memory.
// the result leaves on flow_o from an output register; edge_i is not ready
// until the matrix has been cleared again, a sweep of one entry per cycle over
// 2**(2*clog2(MAX_VERTICES)) entries (4096 for 64 vertices); the sweep also runs
// after reset before the first edge is taken. a stalled flow_o holds its
// item; a new result waits until the old one is taken. the user must write
// vertex_count over the apb port while the block is idle; this is not enforced.
module max_flow_bfs_augment_top #(
  parameter int unsigned MAX_VERTICES = mfb_pkg::MAX_VERTICES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mfb_pkg::APB_AW-1:0]  paddr,
  input  logic [mfb_pkg::APB_DW-1:0]  pwdata,
  output logic [mfb_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  mfb_edge_if.sink                    edge_i,
  mfb_flow_if.source                  flow_o
);
  import mfb_pkg::*;

  localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned AW = 2 * VW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned QW = VW + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_BFS_INIT, S_BFS_POP, S_BFS_POPW, S_SCAN_RD,
    S_SCAN_CHK, S_WALK_P, S_WALK_PW, S_WALK_C, S_AUG_P, S_AUG_PW, S_AUG_F,
    S_AUG_R, S_EMIT
  } state_e;

  state_e state_q;

  logic [VERTEX_W-1:0]   vc_q;
  logic [AW-1:0]         clr_q;
  logic [AW-1:0]         k_q;
  logic [CAP_W-1:0]      cap_q;
  logic                  ld_ok_q, last_q;
  logic [VW-1:0]         sink_q, u_q, w_q, v_q, p_q;
  logic [QW-1:0]         head_q, tail_q;
  logic                  found_q;
  logic [FLOW_W-1:0]     bott_q, total_q;
  logic                  out_valid_q;
  logic [FLOW_W-1:0]     out_flow_q;

  // memories
  logic [FLOW_W-1:0] mat_mem [DEPTH];
  logic [VW-1:0]     par_mem [MAX_VERTICES];
  logic [VW-1:0]     que_mem [MAX_VERTICES];
  logic              seen_mem [MAX_VERTICES];
  logic [FLOW_W-1:0] m_rd_q;
  logic [VW-1:0]     pa_rd_q, q_rd_q;
  logic              sn_rd_q;

  logic              m_we, pa_we, q_we, sn_we, sn_wd;
  logic [AW-1:0]     m_ra, m_wa;
  logic [FLOW_W-1:0] m_wd;
  logic [VW-1:0]     pa_wa, pa_wd, pa_ra, q_wa, q_wd, q_ra, sn_wa, sn_ra;

  logic in_ok, accept, new_vtx, reg_sel;
  logic [VW-1:0] from_idx, to_idx, n_m1;

  assign from_idx = VW'(edge_i.from_vertex - 7'd1);
  assign to_idx   = VW'(edge_i.to_vertex - 7'd1);
  assign in_ok = (edge_i.from_vertex != '0) && (32'(edge_i.from_vertex) <= MAX_VERTICES) &&
                 (edge_i.to_vertex != '0) && (32'(edge_i.to_vertex) <= MAX_VERTICES);
  assign edge_i.ready = (state_q == S_IDLE);
  assign accept = edge_i.valid && edge_i.ready;
  assign new_vtx = !sn_rd_q && (m_rd_q != '0);

  // effective count minus one, clamped to 0..MAX_VERTICES-1
  always_comb begin
    if (vc_q == '0) begin
      n_m1 = '0;
    end else if (32'(vc_q) > MAX_VERTICES) begin
      n_m1 = VW'(MAX_VERTICES - 1);
    end else begin
      n_m1 = VW'(vc_q - 7'd1);
    end
  end

  // apb, register index is the word address
  assign pready = 1'b1;
  assign reg_sel = (paddr[APB_AW-1:2] == REG_VERTEX_COUNT[APB_AW-1:2]);
  assign prdata = reg_sel ? APB_DW'(vc_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= VERTEX_COUNT_RST;
    end else if (psel && penable && pwrite && reg_sel) begin
      vc_q <= pwdata[VERTEX_W-1:0];
    end
  end

  // memory port control
  always_comb begin
    m_we = 1'b0; m_wa = clr_q; m_wd = '0; m_ra = {u_q, w_q};
    pa_we = 1'b0; pa_wa = w_q; pa_wd = u_q; pa_ra = v_q;
    q_we = 1'b0; q_wa = tail_q[VW-1:0]; q_wd = w_q; q_ra = head_q[VW-1:0];
    sn_we = 1'b0; sn_wa = w_q; sn_wd = (w_q == '0); sn_ra = w_q;
    case (state_q)
      S_CLEAR: m_we = 1'b1;
      S_IDLE: m_ra = {from_idx, to_idx};
      S_LOAD: begin
        m_we = ld_ok_q;
        m_wa = k_q;
        m_wd = sat_add(m_rd_q, FLOW_W'(cap_q));
      end
      S_BFS_INIT: begin
        // seen marks swept one per cycle, only the source stays marked
        sn_we = 1'b1;
        q_we = 1'b1; q_wa = '0; q_wd = '0;
      end
      S_SCAN_CHK: begin
        pa_we = new_vtx;
        q_we = new_vtx;
        sn_we = new_vtx;
        sn_wd = 1'b1;
      end
      S_WALK_PW, S_AUG_PW: m_ra = {pa_rd_q, v_q};
      S_AUG_F: begin
        m_we = 1'b1; m_wa = {p_q, v_q}; m_wd = m_rd_q - bott_q;
        m_ra = {v_q, p_q};
      end
      S_AUG_R: begin
        m_we = 1'b1; m_wa = {v_q, p_q}; m_wd = sat_add(m_rd_q, bott_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (m_we) mat_mem[m_wa] <= m_wd;
    m_rd_q <= mat_mem[m_ra];
    if (pa_we) par_mem[pa_wa] <= pa_wd;
    pa_rd_q <= par_mem[pa_ra];
    if (q_we) que_mem[q_wa] <= q_wd;
    q_rd_q <= que_mem[q_ra];
    if (sn_we) seen_mem[sn_wa] <= sn_wd;
    sn_rd_q <= seen_mem[sn_ra];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      total_q <= '0;
      out_valid_q <= 1'b0;
      head_q <= '0;
      tail_q <= '0;
    end else begin
      if (out_valid_q && flow_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            k_q <= {from_idx, to_idx};
            cap_q <= edge_i.edge_capacity;
            ld_ok_q <= in_ok;
            last_q <= edge_i.last_edge;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          sink_q <= n_m1;
          total_q <= '0;
          w_q <= '0;
          if (!last_q) state_q <= S_IDLE;
          else if (n_m1 == '0) state_q <= S_EMIT;
          else state_q <= S_BFS_INIT;
        end
        S_BFS_INIT: begin
          head_q <= '0;
          tail_q <= QW'(1);
          found_q <= 1'b0;
          if (w_q == sink_q) begin
            state_q <= S_BFS_POP;
          end else begin
            w_q <= w_q + 1'b1;
          end
        end
        S_BFS_POP: begin
          if (head_q == tail_q) begin
            v_q <= sink_q;
            bott_q <= '1;
            state_q <= found_q ? S_WALK_P : S_EMIT;
          end else begin
            head_q <= head_q + 1'b1;
            state_q <= S_BFS_POPW;
          end
        end
        S_BFS_POPW: begin
          u_q <= q_rd_q;
          w_q <= '0;
          state_q <= S_SCAN_RD;
        end
        S_SCAN_RD: state_q <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (new_vtx) begin
            tail_q <= tail_q + 1'b1;
            if (w_q == sink_q) found_q <= 1'b1;
          end
          if (w_q == sink_q) begin
            state_q <= S_BFS_POP;
          end else begin
            w_q <= w_q + 1'b1;
            state_q <= S_SCAN_RD;
          end
        end
        S_WALK_P: state_q <= S_WALK_PW;
        S_WALK_PW: begin
          p_q <= pa_rd_q;
          state_q <= S_WALK_C;
        end
        S_WALK_C: begin
          if (m_rd_q < bott_q) bott_q <= m_rd_q;
          if (p_q == '0) begin
            v_q <= sink_q;
            state_q <= S_AUG_P;
          end else begin
            v_q <= p_q;
            state_q <= S_WALK_P;
          end
        end
        S_AUG_P: state_q <= S_AUG_PW;
        S_AUG_PW: begin
          p_q <= pa_rd_q;
          state_q <= S_AUG_F;
        end
        S_AUG_F: state_q <= S_AUG_R;
        S_AUG_R: begin
          v_q <= p_q;
          if (p_q == '0) begin
            total_q <= sat_add(total_q, bott_q);
            w_q <= '0;
            state_q <= S_BFS_INIT;
          end else begin
            state_q <= S_AUG_P;
          end
        end
        S_EMIT: begin
          // wait for the previous result to leave
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            out_flow_q <= total_q;
            clr_q <= '0;
            state_q <= S_CLEAR;
          end
        end
        default: state_q <= S_CLEAR;
      endcase
    end
  end

  assign flow_o.valid = out_valid_q;
  assign flow_o.flow_value = out_flow_q;

endmodule

// File: sim/tb_max_flow_bfs_augment_top.sv
// tb_max_flow_bfs_augment_top: self-checking bench for the edmonds-karp max-flow block
// depends on mfb_pkg, mfb_edge_if, mfb_flow_if and max_flow_bfs_augment_top
// edge items go in, a local max-flow predictor builds expected flows, the checker compares them
module tb_max_flow_bfs_augment_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mfb_pkg::*;

  localparam int unsigned NV = MAX_VERTICES_DEF;
  localparam int unsigned SETTLE_CYCLES = 4400;
  localparam longint unsigned CYCLE_LIMIT = 64'd20000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  mfb_edge_if edge_ch ();
  mfb_flow_if flow_ch ();

  max_flow_bfs_augment_top u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .edge_i(edge_ch.sink), .flow_o(flow_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [FLOW_W-1:0] resid [NV*NV];
  logic [VERTEX_W-1:0] vcount = VERTEX_COUNT_RST;
  logic [FLOW_W-1:0] flow_expected [$];
  int unsigned send_idle_pct = 0, recv_stall_pct = 0;
  bit failed = 1'b0;
  longint unsigned cycle_count = 0;

  function automatic logic [FLOW_W-1:0] edmonds_karp();
    int unsigned n, sink, head, tail, u, v, p;
    int unsigned parent [NV];
    int unsigned bfs_q [NV];
    bit seen [NV];
    logic [FLOW_W-1:0] bottleneck, total;
    n = (vcount == 0) ? 1 : (vcount > NV ? NV : vcount);
    sink = n - 1;
    total = '0;
    if (sink == 0) return '0;
    forever begin
      foreach (seen[i]) seen[i] = 1'b0;
      seen[0] = 1'b1;
      head = 0;
      tail = 1;
      bfs_q[0] = 0;
      while (head < tail) begin
        u = bfs_q[head];
        head++;
        for (int w = 0; w < n; w++)
          if (!seen[w] && resid[u*NV+w] != 0) begin
            seen[w] = 1'b1;
            parent[w] = u;
            bfs_q[tail] = w;
            tail++;
          end
      end
      if (!seen[sink]) break;
      bottleneck = '1;
      v = sink;
      while (v != 0) begin
        p = parent[v];
        if (resid[p*NV+v] < bottleneck) bottleneck = resid[p*NV+v];
        v = p;
      end
      v = sink;
      while (v != 0) begin
        p = parent[v];
        resid[p*NV+v] -= bottleneck;
        resid[v*NV+p] = sat_add(resid[v*NV+p], bottleneck);
        v = p;
      end
      total = sat_add(total, bottleneck);
    end
    return total;
  endfunction

  task automatic load_edge(input int unsigned fv, input int unsigned tv,
                           input int unsigned cap, input int unsigned last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(negedge clk_i);
    edge_ch.valid = 1'b1;
    edge_ch.from_vertex = VERTEX_W'(fv);
    edge_ch.to_vertex = VERTEX_W'(tv);
    edge_ch.edge_capacity = CAP_W'(cap);
    edge_ch.last_edge = (last != 0);
    do @(posedge clk_i); while (!edge_ch.ready);
    if (fv >= 1 && fv <= NV && tv >= 1 && tv <= NV)
      resid[(fv-1)*NV + tv-1] = sat_add(resid[(fv-1)*NV + tv-1], FLOW_W'(cap));
    if (last != 0) begin
      flow_expected.insert(flow_expected.size(), edmonds_karp());
      foreach (resid[i]) resid[i] = '0;
    end
    @(negedge clk_i);
    edge_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (flow_expected.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_vcount(input logic [APB_DW-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_VERTEX_COUNT;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    vcount = value[VERTEX_W-1:0];
  endtask

  // one random graph; mostly small in-range vertices, some out of range
  task automatic random_graph(input int unsigned nedges, input int unsigned span);
    int unsigned fv, tv;
    for (int i = 0; i < nedges; i++) begin
      if ($urandom_range(19) == 0) begin
        fv = $urandom_range(127);
        tv = $urandom_range(127);
      end else begin
        fv = $urandom_range(span, 1);
        tv = $urandom_range(span, 1);
      end
      load_edge(fv, tv, ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(20),
                (i == nedges - 1) ? 1 : 0);
    end
  endtask

  task automatic test_directed();
    write_vcount(4);
    load_edge(1, 2, 16'hFFFF, 0);
    load_edge(1, 2, 16'hFFFF, 0);
    load_edge(2, 4, 16'hFFFF, 0);
    load_edge(1, 3, 5, 0);
    load_edge(3, 4, 0, 0);
    load_edge(3, 3, 9, 0);
    load_edge(0, 4, 7, 0);
    load_edge(7'd65, 2, 7, 0);
    load_edge(7'd127, 7'd127, 1, 0);
    load_edge(4, 7'd64, 3, 1);
    load_edge(0, 0, 0, 1);
    write_vcount(1);
    load_edge(1, 1, 8, 1);
    write_vcount(0);
    load_edge(1, 2, 8, 1);
    write_vcount(64);
    for (int i = 2; i < 64; i++) load_edge(i, 1 + 1 - 1, 16'hFFFF, 0);
    for (int i = 2; i < 64; i++) load_edge(i, 64, 16'hFFFF, (i == 63) ? 1 : 0);
    write_vcount(127);
    load_edge(1, 64, 16'hFFFF, 0);
    load_edge(1, 64, 16'h8000, 1);
  endtask

  task automatic test_random(input int unsigned graphs);
    int unsigned span;
    for (int g = 0; g < graphs; g++) begin
      if ($urandom_range(7) == 0) begin
        write_vcount((g % 5 == 0) ? $urandom_range(127, 65) : $urandom_range(64));
      end
      span = (vcount > 1 && vcount <= NV) ? vcount : 8;
      random_graph($urandom_range(24, 1), span);
    end
  endtask

  task automatic test_pause();
    random_graph(10, 4);
    drain();
    random_graph(10, 4);
  endtask

  initial begin
    edge_ch.valid = 1'b0;
    edge_ch.from_vertex = '0;
    edge_ch.to_vertex = '0;
    edge_ch.edge_capacity = '0;
    edge_ch.last_edge = 1'b0;
    flow_ch.ready = 1'b0;
    foreach (resid[i]) resid[i] = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    write_vcount(6);
    test_random(35);
    send_idle_pct = 45;
    test_random(35);
    send_idle_pct = 0;
    recv_stall_pct = 45;
    test_random(35);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    test_pause();
    test_random(35);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (!failed) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  always @(negedge clk_i)
    flow_ch.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_ni && flow_ch.valid && flow_ch.ready) begin
      if (flow_expected.size() == 0) begin
        $error("flow_value: no result expected, got %0d", flow_ch.flow_value);
        failed = 1'b1;
      end else begin
        if (flow_ch.flow_value !== flow_expected[0]) begin
          $error("flow_value: expected %0d, got %0d", flow_expected[0], flow_ch.flow_value);
          failed = 1'b1;
        end
        flow_expected.delete(0);
      end
    end
  end
endmodule
